[sv/radial_bias_correction_core_assert.svh]
// ---------------------------------------------------------------------------
// Radial bias correction assertion macros
// Shared property forms for the checker of the correction core.
// ---------------------------------------------------------------------------
`ifndef RADIAL_BIAS_CORRECTION_CORE_ASSERT_SVH
`define RADIAL_BIAS_CORRECTION_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBC_ASSERT_IMM(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rbc_pkg.sv]
// ---------------------------------------------------------------------------
// Radial bias correction package
// Widths, codes and beat types shared by the correction core and its parts.
// ---------------------------------------------------------------------------
package rbc_pkg;

    localparam int PIX_W     = 8;
    localparam int COORD_W   = 12;
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_W    = 16;
    localparam int DIFF_W    = 18;
    localparam int SQ_W      = 34;
    localparam int SUM_W     = 35;
    localparam int RAD_W     = 36;
    localparam int ROOT_W    = 18;
    localparam int REM_W     = 20;
    localparam int PROD_W    = 35;
    localparam int T_W       = 36;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_COL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_ROW = 2'd2;

    // Saturation codes.
    localparam logic [1:0] CLIP_NONE = 2'd0;
    localparam logic [1:0] CLIP_HIGH = 2'd1;
    localparam logic [1:0] CLIP_LOW  = 2'd2;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    localparam logic signed [T_W-1:0] T_HIGH = T_W'(255 * 65536);
    localparam logic signed [T_W-1:0] T_HALF = T_W'(32768);

    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] pixel;
        logic [SUM_W-1:0] sum;
    } t_sq_beat;

    typedef struct packed {
        logic              valid;
        logic [PIX_W-1:0]  pixel;
        logic [ROOT_W-1:0] root;
    } t_rt_beat;

endpackage

[sv/rbc_in_if.sv]
// ---------------------------------------------------------------------------
// Radial bias correction input channel
// Valid/ready channel carrying one raw pixel and its coordinates per beat.
// ---------------------------------------------------------------------------
interface rbc_in_if;
    logic                          valid;
    logic                          ready;
    logic [rbc_pkg::PIX_W-1:0]     pixel_in;
    logic [rbc_pkg::COORD_W-1:0]   col;
    logic [rbc_pkg::COORD_W-1:0]   row;

    modport source (output valid, output pixel_in, output col, output row, input ready);
    modport sink   (input valid, input pixel_in, input col, input row, output ready);
endinterface

[sv/rbc_out_if.sv]
// ---------------------------------------------------------------------------
// Radial bias correction output channel
// Valid/ready channel carrying one corrected pixel and its clip code per beat.
// ---------------------------------------------------------------------------
interface rbc_out_if;
    logic                      valid;
    logic                      ready;
    logic [rbc_pkg::PIX_W-1:0] pixel_out;
    logic [1:0]                clip;

    modport source (output valid, output pixel_out, output clip, input ready);
    modport sink   (input valid, input pixel_out, input clip, output ready);
endinterface

[sv/rbc_isqrt.sv]
// ---------------------------------------------------------------------------
// Radial bias correction square root pipeline
// Integer square root of the squared distance, one root bit per stage.
// ---------------------------------------------------------------------------
module rbc_isqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  rbc_pkg::t_sq_beat i_beat,
    output rbc_pkg::t_rt_beat o_beat
);

    localparam int STEPS = rbc_pkg::ROOT_W;

    typedef struct packed {
        logic                       valid;
        logic [rbc_pkg::PIX_W-1:0]  pixel;
        logic [rbc_pkg::RAD_W-1:0]  rad;
        logic [rbc_pkg::ROOT_W-1:0] root;
        logic [rbc_pkg::REM_W-1:0]  rem;
    } t_isq_stage;

    t_isq_stage w_in;
    t_isq_stage r_st [STEPS];

    assign w_in.valid = i_beat.valid;
    assign w_in.pixel = i_beat.pixel;
    assign w_in.rad   = {1'b0, i_beat.sum};
    assign w_in.root  = '0;
    assign w_in.rem   = '0;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        t_isq_stage                  w_src;
        t_isq_stage                  n_st;
        logic [rbc_pkg::REM_W+1:0]   w_acc;
        logic [rbc_pkg::REM_W+1:0]   w_trial;

        if (k == 0) begin : g_first
            assign w_src = w_in;
        end else begin : g_next
            assign w_src = r_st[k-1];
        end

        // Bring down the next two radicand bits and try the candidate 4*root+1.
        always_comb begin
            w_acc   = {w_src.rem, w_src.rad[rbc_pkg::RAD_W-1 -: 2]};
            w_trial = {2'b00, w_src.root, 2'b01};
            n_st    = w_src;
            n_st.rad = w_src.rad << 2;
            if (w_acc >= w_trial) begin
                n_st.rem  = rbc_pkg::REM_W'(w_acc - w_trial);
                n_st.root = {w_src.root[rbc_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_st.rem  = rbc_pkg::REM_W'(w_acc);
                n_st.root = {w_src.root[rbc_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].valid <= 1'b0;
            end else if (i_adv) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_beat.valid = r_st[STEPS-1].valid;
    assign o_beat.pixel = r_st[STEPS-1].pixel;
    assign o_beat.root  = r_st[STEPS-1].root;

endmodule

[sv/radial_bias_correction_core.sv]
// ---------------------------------------------------------------------------
// Radial bias correction core
// Subtracts slope times distance from a configured centre from each pixel,
// rounds half up and clamps the result to 0..255 with a saturation code.
// ---------------------------------------------------------------------------
//  Channel  Dir  Content                      Handshake
//  i_px     in   pixel_in, col, row           valid/ready
//  o_px     out  pixel_out, clip              valid/ready
//  i_cfg_*  in   slope, centre_col, centre_row write enable, no wait
//
//  One pixel per cycle while the output is not stalled. The pipeline is the
//  18-stage square root pipeline plus five stages for offset, squares,
//  sum, slope multiply and clamping.
//  The whole pipeline advances together; a stalled output freezes every
//  stage and drops input ready, so nothing is lost or repeated.
//  Reset clears the valid bits and the three configuration registers.
// ---------------------------------------------------------------------------
module radial_bias_correction_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    rbc_in_if.sink                           i_px,
    rbc_out_if.source                        o_px,
    input  logic                             i_cfg_we,
    input  logic [rbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rbc_pkg::REG_W-1:0]        i_cfg_data
);

    localparam int PW = rbc_pkg::PIX_W;
    localparam int CW = rbc_pkg::COORD_W;
    localparam logic [CW-1:0] COL_LIM = CW'(MAX_WIDTH - 1);
    localparam logic [CW-1:0] ROW_LIM = CW'(MAX_HEIGHT - 1);

    logic signed [rbc_pkg::REG_W-1:0] r_slope;
    logic signed [rbc_pkg::REG_W-1:0] r_centre_col;
    logic signed [rbc_pkg::REG_W-1:0] r_centre_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope      <= '0;
            r_centre_col <= '0;
            r_centre_row <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rbc_pkg::REG_SLOPE:      r_slope      <= i_cfg_data;
                rbc_pkg::REG_CENTRE_COL: r_centre_col <= i_cfg_data;
                rbc_pkg::REG_CENTRE_ROW: r_centre_row <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_adv;
    logic r_out_valid;

    assign w_adv      = !r_out_valid || o_px.ready;
    assign i_px.ready = w_adv;

    // Offset from the centre, Q.4.
    logic [CW-1:0]                    w_col_c;
    logic [CW-1:0]                    w_row_c;
    logic signed [rbc_pkg::DIFF_W-1:0] w_dx;
    logic signed [rbc_pkg::DIFF_W-1:0] w_dy;

    assign w_col_c = (32'(i_px.col) > 32'(MAX_WIDTH - 1))  ? COL_LIM : i_px.col;
    assign w_row_c = (32'(i_px.row) > 32'(MAX_HEIGHT - 1)) ? ROW_LIM : i_px.row;
    assign w_dx = {{2{r_centre_col[rbc_pkg::REG_W-1]}}, r_centre_col} - {2'b00, w_col_c, 4'h0};
    assign w_dy = {{2{r_centre_row[rbc_pkg::REG_W-1]}}, r_centre_row} - {2'b00, w_row_c, 4'h0};

    logic                              r_a_valid;
    logic [PW-1:0]                     r_a_pix;
    logic signed [rbc_pkg::DIFF_W-1:0] r_a_dx;
    logic signed [rbc_pkg::DIFF_W-1:0] r_a_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_px.valid;
            r_a_pix   <= i_px.pixel_in;
            r_a_dx    <= w_dx;
            r_a_dy    <= w_dy;
        end
    end

    // Squares of the offsets.
    logic signed [2*rbc_pkg::DIFF_W-1:0] w_sqx;
    logic signed [2*rbc_pkg::DIFF_W-1:0] w_sqy;

    assign w_sqx = r_a_dx * r_a_dx;
    assign w_sqy = r_a_dy * r_a_dy;

    logic                        r_b_valid;
    logic [PW-1:0]               r_b_pix;
    logic [rbc_pkg::SQ_W-1:0]    r_b_sqx;
    logic [rbc_pkg::SQ_W-1:0]    r_b_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
            r_b_pix   <= r_a_pix;
            r_b_sqx   <= w_sqx[rbc_pkg::SQ_W-1:0];
            r_b_sqy   <= w_sqy[rbc_pkg::SQ_W-1:0];
        end
    end

    rbc_pkg::t_sq_beat r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
        end else if (w_adv) begin
            r_c.valid <= r_b_valid;
            r_c.pixel <= r_b_pix;
            r_c.sum   <= {1'b0, r_b_sqx} + {1'b0, r_b_sqy};
        end
    end

    rbc_pkg::t_rt_beat w_rt;

    rbc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_beat  (r_c),
        .o_beat  (w_rt)
    );

    // Bias term, Q.16.
    logic signed [rbc_pkg::PROD_W-1:0] w_prod;

    assign w_prod = r_slope * $signed({1'b0, w_rt.root});

    logic                              r_m_valid;
    logic [PW-1:0]                     r_m_pix;
    logic signed [rbc_pkg::PROD_W-1:0] r_m_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= w_rt.valid;
            r_m_pix   <= w_rt.pixel;
            r_m_prod  <= w_prod;
        end
    end

    logic signed [rbc_pkg::T_W-1:0] w_t;
    logic        [rbc_pkg::T_W-1:0] w_rnd;
    logic [PW-1:0]                  w_pix_out;
    logic [1:0]                     w_clip;

    assign w_t   = $signed({{(rbc_pkg::T_W-PW-rbc_pkg::FRAC_W){1'b0}}, r_m_pix,
                            {rbc_pkg::FRAC_W{1'b0}}}) - r_m_prod;
    assign w_rnd = w_t + rbc_pkg::T_HALF;

    // Both boundary values themselves count as in range.
    always_comb begin
        if (w_t > rbc_pkg::T_HIGH) begin
            w_pix_out = rbc_pkg::PIX_MAX;
            w_clip    = rbc_pkg::CLIP_HIGH;
        end else if (w_t[rbc_pkg::T_W-1]) begin
            w_pix_out = rbc_pkg::PIX_MIN;
            w_clip    = rbc_pkg::CLIP_LOW;
        end else begin
            w_pix_out = w_rnd[rbc_pkg::FRAC_W +: PW];
            w_clip    = rbc_pkg::CLIP_NONE;
        end
    end

    logic [PW-1:0] r_out_pix;
    logic [1:0]    r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_m_valid;
            r_out_pix   <= w_pix_out;
            r_out_clip  <= w_clip;
        end
    end

    assign o_px.valid     = r_out_valid;
    assign o_px.pixel_out = r_out_pix;
    assign o_px.clip      = r_out_clip;

endmodule

[sv/rbc_checker.sv]
// ---------------------------------------------------------------------------
// Radial bias correction checker
// Port-level properties of the correction core, bound to the top level.
// ---------------------------------------------------------------------------
`include "radial_bias_correction_core_assert.svh"

module rbc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [rbc_pkg::PIX_W-1:0] i_pixel_out,
    input logic [1:0]                i_clip
);

    `RBC_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pixel_out) && $stable(i_clip), "output beat changed while stalled")

    // The pipeline moves as one, so input ready follows the output side.
    `RBC_ASSERT_IMM(a_in_ready_free, !i_out_valid || i_out_ready, i_in_ready, "input not ready while output free")

    `RBC_ASSERT_IMM(a_in_ready_stall, i_out_valid && !i_out_ready, !i_in_ready, "input accepted during output stall")

    `RBC_ASSERT_IMM(a_clip_code, i_out_valid, i_clip == rbc_pkg::CLIP_NONE || i_clip == rbc_pkg::CLIP_HIGH || i_clip == rbc_pkg::CLIP_LOW, "undefined clip code")

    `RBC_ASSERT_IMM(a_clip_high, i_out_valid && i_clip == rbc_pkg::CLIP_HIGH, i_pixel_out == rbc_pkg::PIX_MAX, "high clip without full-scale pixel")

endmodule

bind radial_bias_correction_core rbc_checker u_rbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_px.valid),
    .i_in_ready  (i_px.ready),
    .i_out_valid (o_px.valid),
    .i_out_ready (o_px.ready),
    .i_pixel_out (o_px.pixel_out),
    .i_clip      (o_px.clip)
);
